// ===== rtl/hvc_pkg.sv =====
// Shared types and constants for the heading velocity command block.
// Holds the transaction payload structs, configuration register codes and CORDIC tables.
// No dependencies.
package hvc_pkg;

    // Input transaction payload.
    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [15:0] heading;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic signed [31:0] body_vx;
        logic signed [31:0] body_vy;
        logic signed [15:0] yaw_rate;
    } t_out_item;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_FORWARD_SPEED = 2'd0,
        CFG_MAX_LATERAL_SPEED = 2'd1,
        CFG_HEADING_GAIN      = 2'd2,
        CFG_TURN_RATE         = 2'd3
    } t_cfg_idx;

    // Configuration reset values.
    localparam logic [15:0] MAX_FORWARD_SPEED_RST = 16'd256;
    localparam logic [15:0] MAX_LATERAL_SPEED_RST = 16'd256;
    localparam logic [15:0] HEADING_GAIN_RST      = 16'd2048;
    localparam logic [15:0] TURN_RATE_RST         = 16'd0;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    localparam int ATAN_LEN = 24;
    localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // CORDIC gain correction 1/K in Q1.30, and its square rounded to Q1.30.
    localparam logic signed [63:0] INVK_Q30  = 64'sd652032874;
    localparam logic signed [63:0] INVK2_Q30 =
        (INVK_Q30 * INVK_Q30 + (64'sd1 <<< 29)) >>> 30;

endpackage

// ===== rtl/hvc_in_if.sv =====
// Input channel of the heading velocity command block.
// Carries valid, ready and one pose transaction; depends on hvc_pkg.
interface hvc_in_if;
    import hvc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hvc_out_if.sv =====
// Output channel of the heading velocity command block.
// Carries valid, ready and one velocity command transaction; depends on hvc_pkg.
interface hvc_out_if;
    import hvc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hvc_cordic.sv =====
// Pipelined CORDIC, one register stage per iteration, in rotation or vectoring mode.
// A sideband word travels with each transaction; depends on hvc_pkg for the arctangent table.
module hvc_cordic #(
    parameter int W          = 40,
    parameter int ANGLE_BITS = 16,
    parameter int STAGES     = 16,
    parameter int SIDE_W     = 16,
    parameter bit VECTORING  = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_vld,
    input  logic signed [W-1:0]    i_x,
    input  logic signed [W-1:0]    i_y,
    input  logic [ANGLE_BITS-1:0]  i_z,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_vld,
    output logic signed [W-1:0]    o_x,
    output logic signed [W-1:0]    o_y,
    output logic [ANGLE_BITS-1:0]  o_z,
    output logic [SIDE_W-1:0]      o_side
);
    import hvc_pkg::*;

    logic                  r_v [STAGES];
    logic signed [W-1:0]   r_x [STAGES];
    logic signed [W-1:0]   r_y [STAGES];
    logic [ANGLE_BITS-1:0] r_z [STAGES];
    logic [SIDE_W-1:0]     r_s [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        // Angle step for this iteration, rounded to the angle width.
        localparam logic [32:0] STEP_W =
            (33'(ATAN_TURN32[g]) + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        localparam logic [ANGLE_BITS-1:0] STEP = STEP_W[ANGLE_BITS-1:0];

        logic                  w_v;
        logic signed [W-1:0]   w_x;
        logic signed [W-1:0]   w_y;
        logic signed [W-1:0]   w_xs;
        logic signed [W-1:0]   w_ys;
        logic [ANGLE_BITS-1:0] w_z;
        logic [SIDE_W-1:0]     w_s;
        logic                  w_pos;

        // Stage source: the ports for the first iteration, else the previous stage.
        if (g == 0) begin : g_first
            assign w_v = i_vld;
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = i_z;
            assign w_s = i_side;
        end else begin : g_next
            assign w_v = r_v[g-1];
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_z = r_z[g-1];
            assign w_s = r_s[g-1];
        end

        assign w_xs = w_x >>> g;
        assign w_ys = w_y >>> g;

        // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
        assign w_pos = VECTORING ? !(!w_y[W-1] && (w_y != '0)) : !w_z[ANGLE_BITS-1];

        // Valid bit advances with the pipeline.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_adv) begin
                r_v[g] <= w_v;
            end
        end

        // One micro-rotation.
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_s[g] <= w_s;
                if (w_pos) begin
                    r_x[g] <= w_x - w_ys;
                    r_y[g] <= w_y + w_xs;
                    r_z[g] <= w_z - STEP;
                end else begin
                    r_x[g] <= w_x + w_ys;
                    r_y[g] <= w_y - w_xs;
                    r_z[g] <= w_z + STEP;
                end
            end
        end
    end

    assign o_vld  = r_v[STAGES-1];
    assign o_x    = r_x[STAGES-1];
    assign o_y    = r_y[STAGES-1];
    assign o_z    = r_z[STAGES-1];
    assign o_side = r_s[STAGES-1];

endmodule

// ===== rtl/heading_velocity_command_top.sv =====
// Heading velocity command: bearing to target, world velocity, rotation into the body frame.
// Depends on hvc_pkg, hvc_in_if, hvc_out_if and hvc_cordic.
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline in place.
// Reset clears every stage valid bit and loads the configuration registers with their defaults.
module heading_velocity_command_top #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hvc_in_if.sink            i_in,
    hvc_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  hvc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);
    import hvc_pkg::*;

    localparam int AB  = ANGLE_BITS;
    localparam int VW  = 44;
    localparam int RW1 = 34;
    localparam int RW2 = 40;
    localparam logic signed [AB-1:0] QTR  = AB'(1) <<< (AB - 2);
    localparam logic [AB-1:0]        HALF = {1'b1, {(AB-1){1'b0}}};
    localparam logic signed [RW1-1:0] INVK2 = RW1'(INVK2_Q30);

    logic w_adv;

    // Configuration registers and the speed-gain products.
    logic [15:0] r_max_fwd, r_max_lat, r_gain;
    logic [15:0] r_turn_rate;
    logic [31:0] r_pf, r_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fwd   <= MAX_FORWARD_SPEED_RST;
            r_max_lat   <= MAX_LATERAL_SPEED_RST;
            r_gain      <= HEADING_GAIN_RST;
            r_turn_rate <= TURN_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_FORWARD_SPEED: r_max_fwd   <= i_cfg_data;
                CFG_MAX_LATERAL_SPEED: r_max_lat   <= i_cfg_data;
                CFG_HEADING_GAIN:      r_gain      <= i_cfg_data;
                CFG_TURN_RATE:         r_turn_rate <= i_cfg_data;
                default:               r_gain      <= r_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pf <= r_max_fwd * r_gain;
        r_pl <= r_max_lat * r_gain;
    end

    // The whole pipeline moves when the output register is free or being drained.
    logic r_ov;
    assign w_adv      = !r_ov || o_out.ready;
    assign i_in.ready = w_adv;

    // Stage 0: displacement.
    logic                r0_v;
    logic signed [32:0]  r0_dx, r0_dy;
    logic signed [15:0]  r0_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_adv) begin
            r0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_dx <= 33'(i_in.data.target_x) - 33'(i_in.data.robot_x);
            r0_dy <= 33'(i_in.data.target_y) - 33'(i_in.data.robot_y);
            r0_h  <= i_in.data.heading;
        end
    end

    // Stage 1: find the normalizing shift from the leading one of |dx| | |dy|.
    logic [32:0] w_ax, w_ay, w_m;
    logic [5:0]  w_msb;
    logic        r1_v, r1_zero;
    logic [5:0]  r1_k;
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [15:0] r1_h;

    always_comb begin
        w_ax  = r0_dx[32] ? (~r0_dx + 33'd1) : r0_dx;
        w_ay  = r0_dy[32] ? (~r0_dy + 33'd1) : r0_dy;
        w_m   = w_ax | w_ay;
        w_msb = 6'd0;
        for (int b = 0; b < 33; b++) begin
            if (w_m[b]) begin
                w_msb = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_k    <= 6'd39 - w_msb;
            r1_zero <= (w_m == '0);
            r1_dx   <= r0_dx;
            r1_dy   <= r0_dy;
            r1_h    <= r0_h;
        end
    end

    // Stage 2: scale up and fold the left half plane onto the right.
    logic signed [VW-1:0] w_sx, w_sy;
    logic                 r2_v;
    logic signed [VW-1:0] r2_x, r2_y;
    logic [AB-1:0]        r2_z;
    logic [16:0]          r2_side;

    assign w_sx = VW'(r1_dx) <<< r1_k;
    assign w_sy = VW'(r1_dy) <<< r1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_side <= {r1_zero, r1_h};
            if (w_sx[VW-1]) begin
                r2_x <= -w_sx;
                r2_y <= -w_sy;
                r2_z <= HALF;
            end else begin
                r2_x <= w_sx;
                r2_y <= w_sy;
                r2_z <= '0;
            end
        end
    end

    // Bearing by CORDIC vectoring.
    logic                 w_vec_v;
    logic signed [VW-1:0] w_vec_x, w_vec_y;
    logic [AB-1:0]        w_vec_z;
    logic [16:0]          w_vec_side;

    hvc_cordic #(
        .W(VW), .ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .SIDE_W(17), .VECTORING(1'b1)
    ) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_vld(r2_v), .i_x(r2_x), .i_y(r2_y), .i_z(r2_z), .i_side(r2_side),
        .o_vld(w_vec_v), .o_x(w_vec_x), .o_y(w_vec_y), .o_z(w_vec_z), .o_side(w_vec_side)
    );

    // Stage 3: bearing of zero displacement is zero; fold the angle into a quarter turn.
    logic signed [AB-1:0]  w_b;
    logic                  r3_v;
    logic signed [RW1-1:0] r3_x;
    logic [AB-1:0]         r3_z;
    logic [15:0]           r3_h;

    assign w_b = w_vec_side[16] ? '0 : $signed(w_vec_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= w_vec_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_h <= w_vec_side[15:0];
            if (w_b > QTR || w_b < -QTR) begin
                r3_x <= -INVK2;
                r3_z <= w_b + HALF;
            end else begin
                r3_x <= INVK2;
                r3_z <= w_b;
            end
        end
    end

    // Cosine and sine of the bearing by CORDIC rotation.
    logic                  w_r1_v;
    logic signed [RW1-1:0] w_cos, w_sin;
    logic [AB-1:0]         w_r1_z;
    logic [15:0]           w_r1_h;

    hvc_cordic #(
        .W(RW1), .ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .SIDE_W(16), .VECTORING(1'b0)
    ) u_trig (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_vld(r3_v), .i_x(r3_x), .i_y('0), .i_z(r3_z), .i_side(r3_h),
        .o_vld(w_r1_v), .o_x(w_cos), .o_y(w_sin), .o_z(w_r1_z), .o_side(w_r1_h)
    );

    // Stage 4: speed-gain times cosine and sine.
    logic               r4_v;
    logic signed [66:0] r4_px, r4_py;
    logic signed [15:0] r4_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= w_r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_px <= $signed({1'b0, r_pf}) * w_cos;
            r4_py <= $signed({1'b0, r_pl}) * w_sin;
            r4_h  <= w_r1_h;
        end
    end

    // Stage 5: round to Q.24, negate the heading and fold it into a quarter turn.
    logic signed [66:0]    w_rx, w_ry;
    logic signed [RW2-1:0] w_vx, w_vy;
    logic signed [AB-1:0]  w_ha, w_nh;
    logic                  r5_v;
    logic signed [RW2-1:0] r5_x, r5_y;
    logic [AB-1:0]         r5_z;

    assign w_rx = r4_px + (67'sd1 <<< 25);
    assign w_ry = r4_py + (67'sd1 <<< 25);
    assign w_vx = $signed(w_rx[65:26]);
    assign w_vy = $signed(w_ry[65:26]);

    if (AB >= 16) begin : g_ha_up
        assign w_ha = AB'(r4_h) <<< (AB - 16);
    end else begin : g_ha_down
        assign w_ha = AB'(r4_h >>> (16 - AB));
    end
    assign w_nh = -w_ha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_nh > QTR || w_nh < -QTR) begin
                r5_x <= -w_vx;
                r5_y <= -w_vy;
                r5_z <= w_nh + HALF;
            end else begin
                r5_x <= w_vx;
                r5_y <= w_vy;
                r5_z <= w_nh;
            end
        end
    end

    // Rotation into the body frame.
    logic                  w_r2_v;
    logic signed [RW2-1:0] w_bx, w_by;
    logic [AB-1:0]         w_r2_z;
    logic [15:0]           w_r2_yaw;

    hvc_cordic #(
        .W(RW2), .ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .SIDE_W(16), .VECTORING(1'b0)
    ) u_body (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_vld(r5_v), .i_x(r5_x), .i_y(r5_y), .i_z(r5_z), .i_side(r_turn_rate),
        .o_vld(w_r2_v), .o_x(w_bx), .o_y(w_by), .o_z(w_r2_z), .o_side(w_r2_yaw)
    );

    // Output register: round to Q16.16. The body velocity stays below 2^38 in Q.24,
    // so the rounded value always fits 32 bits and needs no saturation.
    logic signed [RW2-1:0] w_ox, w_oy;
    logic signed [31:0]    r_obx, r_oby;
    logic [15:0]           r_oyaw;

    assign w_ox = w_bx + RW2'(128);
    assign w_oy = w_by + RW2'(128);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_obx  <= $signed(w_ox[RW2-1:8]);
            r_oby  <= $signed(w_oy[RW2-1:8]);
            r_oyaw <= w_r2_yaw;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.data.body_vx  = r_obx;
    assign o_out.data.body_vy  = r_oby;
    assign o_out.data.yaw_rate = $signed(r_oyaw);

    // The residual angles are not needed past their CORDIC units.
    logic w_unused;
    assign w_unused = ^{w_vec_x, w_vec_y, w_r1_z, w_r2_z};

    // A stalled pipeline keeps its transactions.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_v && !w_adv) |=> r5_v)
        else $error("stage valid lost during stall");

    // Zero displacement enters the trig rotation with bearing zero.
    a_zero_bearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_vec_v && w_vec_side[16]) |=> (r3_z == '0 && r3_x == INVK2))
        else $error("zero displacement did not give bearing zero");

    // Nothing leaves the block in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_ov)
        else $error("output valid after reset");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heading_velocity_command_top.
// Drives pose transactions, predicts body-frame velocity commands bit for bit and checks them.
// Depends on hvc_pkg, hvc_in_if, hvc_out_if and the RTL of the block.
module tb;
    import hvc_pkg::*;

    localparam int AB        = 16;
    localparam int STAGES    = 16;
    localparam int LATENCY   = 3 * STAGES + 7;
    localparam int MAX_WAIT  = 19;
    localparam int PHASE_LEN = 300;
    localparam longint CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [15:0] i_cfg_data;

    hvc_in_if  pose_ch ();
    hvc_out_if cmd_ch ();

    heading_velocity_command_top #(.ANGLE_BITS(AB), .CORDIC_STAGES(STAGES)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pose_ch),
        .o_out      (cmd_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Shadow copy of the configuration registers.
    logic [15:0] fwd_speed;
    logic [15:0] lat_speed;
    logic [15:0] gain;
    logic [15:0] yaw_cfg;

    t_out_item cmd_queue[$];
    int        fail_count;
    longint    cycles;
    bit        no_idle;

    // One mismatch, one line.
    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    function automatic longint wrap_turn(longint z);
        return (z <<< (64 - AB)) >>> (64 - AB);
    endfunction

    function automatic longint atan_angle(int i);
        longint unsigned t;
        t = 64'(ATAN_TURN32[i]) + (64'd1 << (31 - AB));
        return longint'(t >> (32 - AB));
    endfunction

    // Vectoring CORDIC: angle of (x, y) as a binary angle.
    function automatic longint bearing_to(longint x, longint y);
        longint z;
        longint m;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        m = (x < 0 ? -x : x) | (y < 0 ? -y : y);
        for (int i = 0; i < 64 && m < (64'sd1 <<< 39); i++) begin
            m = m <<< 1;
            x = x * 2;
            y = y * 2;
        end
        // Left half plane: fold over and start from a half turn.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd1 <<< (AB - 1);
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_angle(i);
            end else begin
                x -= ys;
                y += xs;
                z -= atan_angle(i);
            end
        end
        return wrap_turn(z);
    endfunction

    // Rotation CORDIC of (x, y) by angle z, gain not removed.
    function automatic void rotate_vec(inout longint x, inout longint y, input longint z);
        longint xs;
        longint ys;
        longint quarter;
        quarter = 64'sd1 <<< (AB - 2);
        z = wrap_turn(z);
        if (z > quarter || z < -quarter) begin
            x = -x;
            y = -y;
            z = wrap_turn(z + (64'sd1 <<< (AB - 1)));
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_angle(i);
            end else begin
                x += ys;
                y -= xs;
                z += atan_angle(i);
            end
        end
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    // Expected velocity command for one pose.
    function automatic t_out_item velocity_command(t_in_item p);
        t_out_item r;
        longint dx;
        longint dy;
        longint c;
        longint s;
        longint vx;
        longint vy;
        dx = longint'(p.target_x) - longint'(p.robot_x);
        dy = longint'(p.target_y) - longint'(p.robot_y);
        c = INVK2_Q30;
        s = 0;
        rotate_vec(c, s, bearing_to(dx, dy));
        vx = round_shift(longint'(fwd_speed) * longint'(gain) * c, 26);
        vy = round_shift(longint'(lat_speed) * longint'(gain) * s, 26);
        rotate_vec(vx, vy, -(longint'(p.heading) <<< (AB - 16)));
        r.body_vx  = clamp32(round_shift(vx, 8));
        r.body_vy  = clamp32(round_shift(vy, 8));
        r.yaw_rate = yaw_cfg;
        return r;
    endfunction

    // Register write while the block is idle.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MAX_FORWARD_SPEED: fwd_speed = value;
            CFG_MAX_LATERAL_SPEED: lat_speed = value;
            CFG_HEADING_GAIN:      gain      = value;
            CFG_TURN_RATE:         yaw_cfg   = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] f, logic [15:0] l, logic [15:0] g, logic [15:0] t);
        write_reg(CFG_MAX_FORWARD_SPEED, f);
        write_reg(CFG_MAX_LATERAL_SPEED, l);
        write_reg(CFG_HEADING_GAIN, g);
        write_reg(CFG_TURN_RATE, t);
    endtask

    // Send one pose transaction, predicting its command on acceptance.
    task automatic send_pose(t_in_item p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            pose_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pose_ch.valid = 1'b1;
        pose_ch.data  = p;
        do begin
            @(posedge i_clk);
        end while (!pose_ch.ready);
        cmd_queue = {cmd_queue, velocity_command(p)};
        @(negedge i_clk);
    endtask

    // Drop valid at once so the last pose is not offered again, then wait for all results.
    task automatic drain();
        pose_ch.valid = 1'b0;
        while (cmd_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Random pose: full range, near target, zero displacement or axis aligned.
    function automatic t_in_item random_pose();
        t_in_item p;
        int sh;
        p.robot_x  = $urandom;
        p.robot_y  = $urandom;
        p.heading  = 16'($urandom);
        sh = $urandom_range(0, 30);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                p.target_x = $urandom;
                p.target_y = $urandom;
            end
            3: begin
                p.target_x = p.robot_x;
                p.target_y = p.robot_y;
            end
            4: begin
                p.target_x = p.robot_x + ($signed($urandom) >>> sh);
                p.target_y = p.robot_y;
            end
            5: begin
                p.target_x = p.robot_x;
                p.target_y = p.robot_y + ($signed($urandom) >>> sh);
            end
            default: begin
                p.target_x = p.robot_x + ($signed($urandom) >>> sh);
                p.target_y = p.robot_y + ($signed($urandom) >>> sh);
            end
        endcase
        return p;
    endfunction

    // Directed poses, run with reset configuration; yaw rate is known there.
    typedef struct {
        t_in_item    pose;
        logic [15:0] yaw_want;
    } t_row;

    localparam logic signed [31:0] MINP = 32'sh80000000;
    localparam logic signed [31:0] MAXP = 32'sh7FFFFFFF;

    t_row directed [] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0}, TURN_RATE_RST},
        '{'{32'sd5, -32'sd7, 32'sd5, -32'sd7, 16'sh7FFF}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, 16'sd0}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd1, 16'sd0}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, -32'sd1, 32'sd0, 16'sd0}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd0, -32'sd1, 16'sd0}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, -32'sd1, -32'sd1, 16'sh8000}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd4096, 32'sd4096, 16'sd16384}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd4096, 32'sd4096, -16'sd16384}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd4096, 32'sd0, 16'sd16385}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd4096, 32'sd0, -16'sd16385}, TURN_RATE_RST},
        '{'{MINP, MINP, MAXP, MAXP, 16'sd0}, TURN_RATE_RST},
        '{'{MAXP, MAXP, MINP, MINP, 16'sh7FFF}, TURN_RATE_RST},
        '{'{MINP, MAXP, MAXP, MINP, 16'sh8000}, TURN_RATE_RST},
        '{'{MAXP, MINP, MINP, MAXP, 16'sd12345}, TURN_RATE_RST},
        '{'{MAXP, 32'sd0, MINP, 32'sd0, 16'sd0}, TURN_RATE_RST},
        '{'{32'sd0, MAXP, 32'sd0, MINP, 16'sd0}, TURN_RATE_RST},
        '{'{-32'sd3, 32'sd2, 32'sd9, -32'sd5, -16'sd1}, TURN_RATE_RST},
        '{'{32'sd1, 32'sd1, -32'sd100000, 32'sd1, 16'sd1}, TURN_RATE_RST},
        '{'{32'sd0, 32'sd0, 32'sd1, -32'sd100000, 16'sh4000}, TURN_RATE_RST}
    };

    // Result checker, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (cmd_queue.size() == 0) begin
                report("unexpected transaction", cmd_ch.data.body_vx, 0);
            end else begin
                want = cmd_queue.pop_front();
                if (cmd_ch.data.body_vx !== want.body_vx) begin
                    report("body_vx", cmd_ch.data.body_vx, want.body_vx);
                end
                if (cmd_ch.data.body_vy !== want.body_vy) begin
                    report("body_vy", cmd_ch.data.body_vy, want.body_vy);
                end
                if (cmd_ch.data.yaw_rate !== want.yaw_rate) begin
                    report("yaw_rate", cmd_ch.data.yaw_rate, want.yaw_rate);
                end
            end
        end
    end

    // Output back-pressure: a random stall before each transaction.
    initial begin
        int stall;
        cmd_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                cmd_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            cmd_ch.ready = 1'b1;
            do begin
                @(posedge i_clk);
            end while (!cmd_ch.valid);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        fail_count    = 0;
        cycles        = 0;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MAX_FORWARD_SPEED;
        i_cfg_data    = '0;
        pose_ch.valid = 1'b0;
        pose_ch.data  = '0;
        fwd_speed     = MAX_FORWARD_SPEED_RST;
        lat_speed     = MAX_LATERAL_SPEED_RST;
        gain          = HEADING_GAIN_RST;
        yaw_cfg       = TURN_RATE_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed poses with reset configuration.
        foreach (directed[k]) begin
            if (velocity_command(directed[k].pose).yaw_rate !== directed[k].yaw_want) begin
                report("directed yaw_rate", yaw_cfg, directed[k].yaw_want);
            end
            send_pose(directed[k].pose);
        end
        drain();

        // Random phases over several settings; each ends with the sender held off.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
                1: set_config(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
                2: set_config(16'hFFFF, 16'h0001, 16'h1000, 16'hFFFF);
                default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom));
            endcase
            no_idle = (ph == 3);
            repeat (PHASE_LEN) send_pose(random_pose());
            drain();
            no_idle = 1'b0;
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && cmd_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
